// ===== design/lbs_pkg.sv =====
package lbs_pkg;

  localparam int BONES          = 4;
  localparam int COEFS          = BONES * 16;
  localparam int IDX_W          = $clog2(COEFS);
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W      = 3;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_VERTEX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESH_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z      = 3'd5;

  // a holds vertex x for a vertex request, the coefficient for a load
  typedef struct packed {
    logic              is_vertex;
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } item_t;

  typedef struct packed {
    logic [30:0]        radius;
    logic [30:0]        mesh_length;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } cfg_t;

endpackage

// ===== design/lbs_div.sv =====
module lbs_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic          neg_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [QW:0]   vld_q;
  logic [QW:0]   neg_q;
  logic [QW:0]   ovf_q;
  logic [NW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic [NW-1:0] trial  [1:QW];
  logic [QW:1]   take;

  always_comb begin
    for (int s = 1; s <= QW; s++) begin
      trial[s] = NW'(den_q[s-1]) << (QW - s);
      take[s]  = rem_q[s-1] >= trial[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= num_i >= (NW'(den_i) << QW);
      side_q[0] <= side_i;
      for (int s = 1; s <= QW; s++) begin
        rem_q[s]  <= take[s] ? rem_q[s-1] - trial[s] : rem_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (QW'(take[s]) << (QW - s));
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign neg_o   = neg_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== design/lbs_front.sv =====
module lbs_front
  import lbs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [IDX_W-1:0]   coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic signed [31:0] vertex_z_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  item_t            item_in;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;

  always_comb begin
    item_in.is_vertex = (action_i == ACT_VERTEX);
    item_in.idx       = coef_index_i;
    item_in.a         = item_in.is_vertex ? vertex_x_i : coef_value_i;
    item_in.b         = vertex_y_i;
    item_in.c         = vertex_z_i;
  end

  assign in_stall_o   = (cnt_q == CNT_W'(DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign cnt_d        = cnt_q + CNT_W'(push) - CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

// ===== design/lbs_back.sv =====
module lbs_back
  import lbs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] skinned_x_o,
  output logic signed [31:0] skinned_y_o,
  output logic signed [31:0] skinned_z_o
);

  localparam int F   = FRAC_BITS;
  localparam int PW  = 64 - F;
  localparam int QWB = F + 3;
  localparam int NWB = F + 34;
  localparam int EW  = F + 7;
  localparam int MW  = F + 34;
  localparam int SWI = $bits(item_t);
  localparam logic signed [63:0]   HALF64 = 64'sd1 <<< (F - 1);
  localparam logic signed [31:0]   ONE32  = 32'sd1 <<< F;
  localparam logic signed [EW-1:0] ONE_E  = EW'(1) << F;
  localparam logic signed [EW-1:0] HALF_E = EW'(1) << (F - 1);
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    rnd = (v + HALF64) >>> F;
  endfunction

  function automatic logic signed [PW-1:0] mulq(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    logic signed [63:0] p;
    p    = 64'(x) * 64'(y);
    mulq = PW'(rnd(p));
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat_div(input logic neg, input logic ovf,
                                                 input logic [31:0] q);
    if (neg) begin
      sat_div = (ovf || q > 32'h80000000) ? 32'sh80000000 : $signed(-q);
    end else begin
      sat_div = (ovf || q[31]) ? 32'sh7fffffff : $signed(q);
    end
  endfunction

  function automatic logic [F:0] clamp_unit(input logic signed [EW-1:0] v);
    if (v < 0) begin
      clamp_unit = '0;
    end else if (v > ONE_E) begin
      clamp_unit = ONE_E[F:0];
    end else begin
      clamp_unit = v[F:0];
    end
  endfunction

  function automatic logic signed [EW-1:0] abs_e(input logic signed [EW-1:0] v);
    abs_e = (v < 0) ? -v : v;
  endfunction

  logic en;
  logic [30:0] rad, len;

  assign en         = !(out_valid_o && out_stall_i);
  assign item_pop_o = en && item_valid_i;
  assign rad        = (cfg_i.radius == '0) ? 31'd1 : cfg_i.radius;
  assign len        = (cfg_i.mesh_length == '0) ? 31'd1 : cfg_i.mesh_length;

  // x * radius
  logic               a_vld_q;
  item_t              a_item_q;
  logic signed [63:0] a_prod_q;

  // x scaled = 2 * x * radius / mesh_length
  logic [63:0] a_mag;
  logic        da_vld, da_neg, da_ovf;
  logic [31:0] da_quo;
  logic [SWI-1:0] da_side;
  item_t       da_item;

  assign a_mag = a_prod_q[63] ? 64'(-a_prod_q) : 64'(a_prod_q);

  lbs_div #(.NW(64), .DW(31), .QW(32), .SW(SWI)) u_div_scale (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q),
    .num_i(a_mag << 1), .den_i(len), .neg_i(a_prod_q[63]), .side_i(a_item_q),
    .valid_o(da_vld), .neg_o(da_neg), .ovf_o(da_ovf), .quo_o(da_quo), .side_o(da_side)
  );

  assign da_item = item_t'(da_side);

  logic  b_vld_q;
  item_t b_item_q;
  item_t b_item_d;

  always_comb begin
    b_item_d = da_item;
    if (da_item.is_vertex) begin
      b_item_d.a = sat_div(da_neg, da_ovf, da_quo);
    end
  end

  // bone position t = 2 * xs / radius + 2
  logic            db_vld, db_neg, db_ovf;
  logic [QWB-1:0]  db_quo;
  logic [SWI-1:0]  db_side;

  lbs_div #(.NW(NWB), .DW(31), .QW(QWB), .SW(SWI)) u_div_pos (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_vld_q),
    .num_i(NWB'(mag32(b_item_q.a)) << (F + 1)), .den_i(rad), .neg_i(b_item_q.a[31]),
    .side_i(b_item_q),
    .valid_o(db_vld), .neg_o(db_neg), .ovf_o(db_ovf), .quo_o(db_quo), .side_o(db_side)
  );

  logic [QWB-1:0]      t_m;
  logic signed [EW-1:0] t_u, t_s, d0, d3;
  logic [F:0]          w_d [BONES];

  always_comb begin
    t_m    = db_ovf ? '1 : db_quo;
    t_u    = $signed({{(EW - QWB){1'b0}}, t_m});
    t_s    = (db_neg ? -t_u : t_u) + (ONE_E <<< 1);
    d0     = t_s - HALF_E;
    d3     = EW'(7) * HALF_E - t_s;
    w_d[0] = clamp_unit(ONE_E - ((d0 > 0) ? d0 : '0));
    w_d[1] = clamp_unit(ONE_E - abs_e(t_s - EW'(3) * HALF_E));
    w_d[2] = clamp_unit(ONE_E - abs_e(t_s - EW'(5) * HALF_E));
    w_d[3] = clamp_unit(ONE_E - ((d3 > 0) ? d3 : '0));
  end

  logic       w_vld_q;
  item_t      w_item_q;
  logic [F:0] w_q [BONES];

  // bone transforms
  logic signed [31:0] mat_q [COEFS];
  logic signed [31:0] vv [4];
  logic signed [PW-1:0] m1_p_d [COEFS];

  always_comb begin
    vv[0] = w_item_q.a;
    vv[1] = w_item_q.b;
    vv[2] = w_item_q.c;
    vv[3] = ONE32;
    for (int i = 0; i < COEFS; i++) begin
      m1_p_d[i] = mulq(mat_q[i], vv[i & 3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && w_vld_q && !w_item_q.is_vertex) begin
      mat_q[w_item_q.idx] <= w_item_q.a;
    end
  end

  logic                 m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q;
  logic signed [PW-1:0] m1_p_q [COEFS];
  logic [F:0]           m1_w_q [BONES];
  logic [F:0]           m2_w_q [BONES];
  logic signed [31:0]   m2_s_q [BONES * 4];
  logic signed [MW-1:0] m3_wp_q [BONES * 4];
  logic signed [31:0]   m4_acc_q [4];

  logic signed [31:0]   m2_s_d [BONES * 4];
  logic signed [MW-1:0] m3_wp_d [BONES * 4];
  logic signed [31:0]   m4_acc_d [4];

  always_comb begin
    logic signed [63:0] sum;
    for (int k = 0; k < BONES * 4; k++) begin
      sum = 64'(m1_p_q[4*k]) + 64'(m1_p_q[4*k+1]) + 64'(m1_p_q[4*k+2])
          + 64'(m1_p_q[4*k+3]);
      m2_s_d[k]  = sat32(sum);
      m3_wp_d[k] = MW'(64'(m2_s_q[k]) * 64'($signed({1'b0, m2_w_q[k >> 2]})));
    end
    for (int r = 0; r < 4; r++) begin
      sum = '0;
      for (int j = 0; j < BONES; j++) begin
        sum = sum + 64'(m3_wp_q[j*4+r]);
      end
      m4_acc_d[r] = sat32(rnd(sum));
    end
  end

  // perspective divide
  logic        dc_vld [3];
  logic        dc_neg [3];
  logic        dc_ovf [3];
  logic [31:0] dc_quo [3];
  logic        dc_zero [3];
  logic        w_zero;
  logic [31:0] w_mag;

  assign w_zero = (m4_acc_q[3] == '0);
  assign w_mag  = w_zero ? 32'd1 : mag32(m4_acc_q[3]);

  for (genvar r = 0; r < 3; r++) begin : g_div_w
    lbs_div #(.NW(64), .DW(32), .QW(32), .SW(1)) u_div_w (
      .clk_i, .rst_ni, .en_i(en), .valid_i(m4_vld_q),
      .num_i(64'(mag32(m4_acc_q[r])) << F), .den_i(w_mag),
      .neg_i(m4_acc_q[r][31] ^ m4_acc_q[3][31]), .side_i(w_zero),
      .valid_o(dc_vld[r]), .neg_o(dc_neg[r]), .ovf_o(dc_ovf[r]), .quo_o(dc_quo[r]),
      .side_o(dc_zero[r])
    );
  end

  // rotation v + 2 * (w * (q x v) + q x (q x v))
  logic signed [31:0] qv [3];
  assign qv[0] = cfg_i.quat_x;
  assign qv[1] = cfg_i.quat_y;
  assign qv[2] = cfg_i.quat_z;

  logic                 p_vld_q, r1_vld_q, r2_vld_q, r3_vld_q, r4_vld_q, r5_vld_q;
  logic signed [31:0]   p_q [3];
  logic signed [31:0]   r1_p_q [3];
  logic signed [31:0]   r2_p_q [3];
  logic signed [31:0]   r3_p_q [3];
  logic signed [31:0]   r4_p_q [3];
  logic signed [PW-1:0] r1_pa_q [3];
  logic signed [PW-1:0] r1_pb_q [3];
  logic signed [31:0]   r2_uv_q [3];
  logic signed [PW-1:0] r3_pa_q [3];
  logic signed [PW-1:0] r3_pb_q [3];
  logic signed [PW-1:0] r3_m_q [3];
  logic signed [PW-1:0] r4_m_q [3];
  logic signed [31:0]   r4_uuv_q [3];
  logic signed [31:0]   r5_o_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      w_vld_q  <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      r5_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q  <= item_valid_i;
      b_vld_q  <= da_vld;
      w_vld_q  <= db_vld;
      m1_vld_q <= w_vld_q && w_item_q.is_vertex;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      m4_vld_q <= m3_vld_q;
      p_vld_q  <= dc_vld[0] && dc_vld[1] && dc_vld[2];
      r1_vld_q <= p_vld_q;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      r5_vld_q <= r4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= item_i;
      a_prod_q <= 64'(item_i.a) * 64'($signed({1'b0, rad}));
      b_item_q <= b_item_d;
      w_item_q <= item_t'(db_side);
      for (int j = 0; j < BONES; j++) begin
        w_q[j]    <= w_d[j];
        m1_w_q[j] <= w_q[j];
        m2_w_q[j] <= m1_w_q[j];
      end
      for (int i = 0; i < COEFS; i++) begin
        m1_p_q[i] <= m1_p_d[i];
      end
      for (int k = 0; k < BONES * 4; k++) begin
        m2_s_q[k]  <= m2_s_d[k];
        m3_wp_q[k] <= m3_wp_d[k];
      end
      for (int r = 0; r < 4; r++) begin
        m4_acc_q[r] <= m4_acc_d[r];
      end
      for (int r = 0; r < 3; r++) begin
        p_q[r]      <= dc_zero[r] ? 32'sd0 : sat_div(dc_neg[r], dc_ovf[r], dc_quo[r]);
        r1_pa_q[r]  <= mulq(qv[NXT[r]], p_q[PRV[r]]);
        r1_pb_q[r]  <= mulq(qv[PRV[r]], p_q[NXT[r]]);
        r1_p_q[r]   <= p_q[r];
        r2_uv_q[r]  <= sat32(64'(r1_pa_q[r]) - 64'(r1_pb_q[r]));
        r2_p_q[r]   <= r1_p_q[r];
        r3_pa_q[r]  <= mulq(qv[NXT[r]], r2_uv_q[PRV[r]]);
        r3_pb_q[r]  <= mulq(qv[PRV[r]], r2_uv_q[NXT[r]]);
        r3_m_q[r]   <= mulq(r2_uv_q[r], cfg_i.quat_w);
        r3_p_q[r]   <= r2_p_q[r];
        r4_uuv_q[r] <= sat32(64'(r3_pa_q[r]) - 64'(r3_pb_q[r]));
        r4_m_q[r]   <= r3_m_q[r];
        r4_p_q[r]   <= r3_p_q[r];
        r5_o_q[r]   <= sat32(64'(r4_p_q[r])
                             + ((64'(r4_m_q[r]) + 64'(r4_uuv_q[r])) <<< 1));
      end
    end
  end

  assign out_valid_o = r5_vld_q;
  assign skinned_x_o = r5_o_q[0];
  assign skinned_y_o = r5_o_q[1];
  assign skinned_z_o = r5_o_q[2];

endmodule

// ===== design/vertex_linear_blend_skinning.sv =====
// Values are Q16.16 at the default FRAC_BITS; the pipelined dividers
// compute one quotient bit per stage.
// Throughput: one request per cycle, loads and vertices alike, while the output is not stalled.
// The queue absorbs QUEUE_DEPTH requests while the output is stalled.
// Reset clears control state and loads the register defaults;
// bone matrices are undefined until written.
module vertex_linear_blend_skinning
  import lbs_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [IDX_W-1:0]     coef_index_i,
  input  logic signed [31:0]   coef_value_i,
  input  logic signed [31:0]   vertex_x_i,
  input  logic signed [31:0]   vertex_y_i,
  input  logic signed [31:0]   vertex_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   skinned_x_o,
  output logic signed [31:0]   skinned_y_o,
  output logic signed [31:0]   skinned_z_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius      <= 31'(32'sd1 <<< FRAC_BITS);
      cfg_q.mesh_length <= 31'(32'sd2 <<< FRAC_BITS);
      cfg_q.quat_w      <= 32'sd1 <<< FRAC_BITS;
      cfg_q.quat_x      <= '0;
      cfg_q.quat_y      <= '0;
      cfg_q.quat_z      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RADIUS:      cfg_q.radius      <= cfg_data_i[30:0];
        REG_MESH_LENGTH: cfg_q.mesh_length <= cfg_data_i[30:0];
        REG_QUAT_W:      cfg_q.quat_w      <= $signed(cfg_data_i);
        REG_QUAT_X:      cfg_q.quat_x      <= $signed(cfg_data_i);
        REG_QUAT_Y:      cfg_q.quat_y      <= $signed(cfg_data_i);
        REG_QUAT_Z:      cfg_q.quat_z      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  lbs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .action_i, .coef_index_i, .coef_value_i,
    .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .item_valid_o(item_valid), .item_o(item), .pop_i(item_pop)
  );

  lbs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q),
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop),
    .out_valid_o, .out_stall_i,
    .skinned_x_o, .skinned_y_o, .skinned_z_o
  );

endmodule
